// ===== design/sprite_frame_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer assertion macros
// Concurrent property checks shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Field widths, codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int MAX_FRAMES_DEF  = 16;
    localparam int SPRITE_BITS_DEF = 16;

    localparam int FC_W      = 5;
    localparam int MODE_W    = 3;
    localparam int RATE_W    = 16;
    localparam int SPEED_W   = 16;
    localparam int OP_W      = 2;
    localparam int ELAPSED_W = 16;
    localparam int SLOT_W    = 4;
    localparam int SPRITE_W  = 16;
    localparam int START_W   = 4;
    localparam int FPOS_W    = 4;

    localparam int POS_W     = FC_W;
    localparam int PROD1_W   = ELAPSED_W + SPEED_W;
    localparam int PROD2_W   = PROD1_W + RATE_W;
    localparam int DROP_W    = 20;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = PROD2_W - DROP_W + 1;
    localparam int ADV_W     = SUM_W - FRAC_W;
    localparam int REM_W     = POS_W + 2;
    localparam int CNT_W     = $clog2(ADV_W + 1);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_ONESHOT     = 3'd0,
        MODE_LOOP        = 3'd1,
        MODE_PINGPONG    = 3'd2,
        MODE_REV_ONESHOT = 3'd3,
        MODE_REV_LOOP    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_FRAME_COUNT  = 2'd0,
        REG_ANIM_MODE    = 2'd1,
        REG_FRAME_RATE   = 2'd2,
        REG_SPEED_FACTOR = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [FC_W-1:0]    frame_count;
        logic [MODE_W-1:0]  anim_mode;
        logic [RATE_W-1:0]  frame_rate;
        logic [SPEED_W-1:0] speed_factor;
    } t_cfg;

    typedef struct packed {
        logic table_we;
        logic restart;
        logic tick_start;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_step;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic tick_ok;
        logic div_done;
    } t_dp_sts;

endpackage

// ===== design/sfs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [sfs_pkg::OP_W-1:0]      opcode;
    logic [sfs_pkg::ELAPSED_W-1:0] elapsed;
    logic [sfs_pkg::SLOT_W-1:0]    entry_slot;
    logic [sfs_pkg::SPRITE_W-1:0]  entry_sprite;
    logic [sfs_pkg::START_W-1:0]   start_frame;

    modport source (
        output valid, opcode, elapsed, entry_slot, entry_sprite, start_frame,
        input  ready
    );
    modport sink (
        input  valid, opcode, elapsed, entry_slot, entry_sprite, start_frame,
        output ready
    );
endinterface

interface sfs_out_if;
    logic                         valid;
    logic                         ready;
    logic [sfs_pkg::SPRITE_W-1:0] sprite_id;
    logic [sfs_pkg::FPOS_W-1:0]   frame_pos;
    logic                         still_playing;

    modport source (
        output valid, sprite_id, frame_pos, still_playing,
        input  ready
    );
    modport sink (
        input  valid, sprite_id, frame_pos, still_playing,
        output ready
    );
endinterface

// ===== design/sfs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer RAM
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module sfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer controller
// Sequences item decode, phase multiply, remainder steps and result hand-off.
// ----------------------------------------------------------------------------
module sfs_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [sfs_pkg::OP_W-1:0] i_opcode,
    input  logic                     i_out_ready,
    input  sfs_pkg::t_dp_sts         i_sts,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output sfs_pkg::t_dp_cmd         o_cmd
);
    import sfs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL1   = 8'b0000_0010,
        S_MUL2   = 8'b0000_0100,
        S_SUM    = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_STEP   = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_LOAD: begin
                            o_cmd.table_we = 1'b1;
                        end
                        OP_RESTART: begin
                            o_cmd.restart = 1'b1;
                        end
                        OP_TICK: begin
                            if (i_sts.tick_ok) begin
                                o_cmd.tick_start = 1'b1;
                                n_state          = S_MUL1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_STEP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/sfs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer datapath
// Phase accumulator, serial remainder unit, index stepper and frame table.
// ----------------------------------------------------------------------------
module sfs_datapath #(
    parameter int MAX_FRAMES  = sfs_pkg::MAX_FRAMES_DEF,
    parameter int SPRITE_BITS = sfs_pkg::SPRITE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfs_pkg::t_cfg                 i_cfg,
    input  sfs_pkg::t_dp_cmd              i_cmd,
    input  logic [sfs_pkg::ELAPSED_W-1:0] i_elapsed,
    input  logic [sfs_pkg::SLOT_W-1:0]    i_entry_slot,
    input  logic [sfs_pkg::SPRITE_W-1:0]  i_entry_sprite,
    input  logic [sfs_pkg::START_W-1:0]   i_start_frame,
    output sfs_pkg::t_dp_sts              o_sts,
    output logic [sfs_pkg::SPRITE_W-1:0]  o_sprite_id,
    output logic [sfs_pkg::FPOS_W-1:0]    o_frame_pos,
    output logic                          o_still_playing
);
    import sfs_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);

    logic [ELAPSED_W-1:0]   r_elapsed;
    logic [PROD1_W-1:0]     r_prod1;
    logic [PROD2_W-1:0]     r_prod2;
    logic [ADV_W-1:0]       r_adv;
    logic [ADV_W-1:0]       r_dvd;
    logic [REM_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic [POS_W-1:0]       r_pos;
    logic [FRAC_W-1:0]      r_phase;
    logic                   r_playing;
    logic                   r_reversing;
    logic [SPRITE_W-1:0]    r_out_sprite;
    logic [FPOS_W-1:0]      r_out_pos;
    logic                   r_out_playing;

    logic [POS_W-1:0]       w_n;
    logic [POS_W-1:0]       w_pos_clamp;
    logic [SUM_W-1:0]       w_sum;
    logic [ADV_W-1:0]       w_adv;
    logic                   w_pingpong;
    logic [REM_W-1:0]       w_nn;
    logic [REM_W-1:0]       w_div;
    logic [REM_W-1:0]       w_top;
    logic [REM_W-1:0]       w_trial;
    logic [REM_W-1:0]       w_p;
    logic [REM_W-1:0]       w_lp;
    logic [REM_W-1:0]       w_p1;
    logic                   w_rv1;
    logic [REM_W-1:0]       w_t;
    logic [REM_W-1:0]       w_t2;
    logic [POS_W-1:0]       n_step_pos;
    logic                   n_step_playing;
    logic                   n_step_rev;
    logic                   w_table_we;
    logic [SPRITE_BITS-1:0] w_rdata;

    assign w_n = (32'(i_cfg.frame_count) > MAX_FRAMES) ? POS_W'(MAX_FRAMES)
                                                        : i_cfg.frame_count;
    assign w_pos_clamp = (r_pos >= w_n) ? (w_n - POS_W'(1)) : r_pos;

    assign w_sum = SUM_W'(r_phase) + SUM_W'(r_prod2[PROD2_W-1:DROP_W]);
    assign w_adv = w_sum[SUM_W-1:FRAC_W];

    assign w_pingpong = (i_cfg.anim_mode == MODE_PINGPONG);
    assign w_nn       = REM_W'(w_n);
    assign w_top      = {w_nn[REM_W-2:0], 1'b0} - REM_W'(3);
    assign w_div      = w_pingpong ? ({w_nn[REM_W-2:0], 1'b0} - REM_W'(2)) : w_nn;
    assign w_trial    = {r_rem[REM_W-2:0], r_dvd[ADV_W-1]};
    assign w_p        = REM_W'(r_pos);

    assign o_sts.tick_ok  = r_playing && (w_n != '0) && (i_cfg.frame_rate != '0);
    assign o_sts.div_done = (r_cnt == '0);

    always_comb begin
        n_step_pos     = r_pos;
        n_step_playing = r_playing;
        n_step_rev     = r_reversing;
        w_lp           = w_p + r_rem;
        w_p1           = '0;
        w_rv1          = 1'b0;
        w_t            = '0;
        w_t2           = '0;
        case (i_cfg.anim_mode)
            MODE_ONESHOT: begin
                if (r_adv >= ADV_W'(w_n - r_pos)) begin
                    n_step_pos     = w_n - POS_W'(1);
                    n_step_playing = 1'b0;
                end else begin
                    n_step_pos = r_pos + POS_W'(r_adv);
                end
            end
            MODE_LOOP: begin
                if (w_lp >= w_nn) begin
                    n_step_pos = POS_W'(w_lp - w_nn);
                end else begin
                    n_step_pos = POS_W'(w_lp);
                end
            end
            MODE_PINGPONG: begin
                if (w_n == POS_W'(1)) begin
                    n_step_pos = '0;
                    n_step_rev = r_reversing ^ r_adv[0];
                end else begin
                    // take the first step by hand, then jump around the bounce cycle
                    if (r_reversing) begin
                        if (w_p == '0) begin
                            w_p1  = REM_W'(1);
                            w_rv1 = 1'b0;
                        end else begin
                            w_p1  = w_p - REM_W'(1);
                            w_rv1 = 1'b1;
                        end
                    end else if (w_p + REM_W'(1) >= w_nn) begin
                        w_p1  = w_nn - REM_W'(2);
                        w_rv1 = 1'b1;
                    end else begin
                        w_p1  = w_p + REM_W'(1);
                        w_rv1 = 1'b0;
                    end
                    w_t  = w_rv1 ? (w_top - w_p1) : (w_p1 - REM_W'(1));
                    w_t2 = w_t + r_rem;
                    if (w_t2 >= w_div) begin
                        w_t2 = w_t2 - w_div;
                    end
                    if (w_t2 < w_nn - REM_W'(1)) begin
                        n_step_pos = POS_W'(w_t2 + REM_W'(1));
                        n_step_rev = 1'b0;
                    end else begin
                        n_step_pos = POS_W'(w_top - w_t2);
                        n_step_rev = 1'b1;
                    end
                end
            end
            MODE_REV_ONESHOT: begin
                if (r_adv > ADV_W'(r_pos)) begin
                    n_step_pos     = '0;
                    n_step_playing = 1'b0;
                end else begin
                    n_step_pos = r_pos - POS_W'(r_adv);
                end
            end
            MODE_REV_LOOP: begin
                if (r_rem > w_p) begin
                    n_step_pos = POS_W'(w_p + w_nn - r_rem);
                end else begin
                    n_step_pos = POS_W'(w_p - r_rem);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= '0;
            r_playing   <= 1'b1;
            r_reversing <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_pos       <= POS_W'(i_start_frame);
                r_phase     <= '0;
                r_playing   <= 1'b1;
                r_reversing <= 1'b0;
            end
            if (i_cmd.sum) begin
                r_phase <= w_sum[FRAC_W-1:0];
                r_pos   <= w_pos_clamp;
                r_cnt   <= CNT_W'(ADV_W);
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.step && (r_adv != '0)) begin
                r_pos       <= n_step_pos;
                r_playing   <= n_step_playing;
                r_reversing <= n_step_rev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_elapsed <= i_elapsed;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= PROD1_W'(r_elapsed) * PROD1_W'(i_cfg.speed_factor);
        end
        if (i_cmd.mul2) begin
            r_prod2 <= PROD2_W'(r_prod1) * PROD2_W'(i_cfg.frame_rate);
        end
        if (i_cmd.sum) begin
            r_adv <= w_adv;
            r_dvd <= w_pingpong ? (w_adv - ADV_W'(1)) : w_adv;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[ADV_W-2:0], 1'b0};
            r_rem <= (w_trial >= w_div) ? (w_trial - w_div) : w_trial;
        end
        if (i_cmd.out_load) begin
            r_out_sprite  <= SPRITE_W'(w_rdata);
            r_out_pos     <= r_pos[FPOS_W-1:0];
            r_out_playing <= r_playing;
        end
    end

    assign w_table_we = i_cmd.table_we && (32'(i_entry_slot) < MAX_FRAMES);

    sfs_ram #(
        .WIDTH (SPRITE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_frame_table (
        .i_clk   (i_clk),
        .i_we    (w_table_we),
        .i_waddr (AW'(i_entry_slot)),
        .i_wdata (SPRITE_BITS'(i_entry_sprite)),
        .i_raddr (AW'(r_pos)),
        .o_rdata (w_rdata)
    );

    assign o_sprite_id     = r_out_sprite;
    assign o_frame_pos     = r_out_pos;
    assign o_still_playing = r_out_playing;

endmodule

// ===== design/sprite_frame_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer unit
// Frame sequencer for one animation clip with APB configuration registers.
// ----------------------------------------------------------------------------
// Port     Dir  Handshake        Carries
// i_in     in   valid/ready      opcode, elapsed, entry_slot, entry_sprite,
//                                start_frame
// o_out    out  valid/ready      sprite_id, frame_pos, still_playing
// APB      in   psel/penable     frame_count, anim_mode, frame_rate,
//                                speed_factor at 0x0, 0x4, 0x8, 0xC
//
// An enabled tick runs from its transfer through two multiply stages, one
// phase add, the bit-serial remainder unit (13 dividend bits, one per cycle,
// then the done check), index step, table read and result load before the
// next item can be taken. Loads, restarts, unused opcodes and ticks while
// stopped or disabled complete in their transfer cycle.
// Reset is synchronous and needs no clearing pass; the table is unset.
// A result waiting on o_out stalls only the next tick, at its final load.
// ----------------------------------------------------------------------------
`include "sprite_frame_sequencer_unit_assert.svh"

module sprite_frame_sequencer_unit #(
    parameter int MAX_FRAMES  = sfs_pkg::MAX_FRAMES_DEF,
    parameter int SPRITE_BITS = sfs_pkg::SPRITE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfs_in_if.sink                         i_in,
    sfs_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import sfs_pkg::*;

    t_cfg    r_cfg;
    logic    w_cfg_we;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count  <= '0;
            r_cfg.anim_mode    <= MODE_LOOP;
            r_cfg.frame_rate   <= '0;
            r_cfg.speed_factor <= SPEED_RESET;
        end else if (w_cfg_we) begin
            case (paddr[3:2])
                REG_FRAME_COUNT:  r_cfg.frame_count  <= pwdata[FC_W-1:0];
                REG_ANIM_MODE:    r_cfg.anim_mode    <= pwdata[MODE_W-1:0];
                REG_FRAME_RATE:   r_cfg.frame_rate   <= pwdata[RATE_W-1:0];
                REG_SPEED_FACTOR: r_cfg.speed_factor <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_COUNT:  prdata = APB_DATA_W'(r_cfg.frame_count);
            REG_ANIM_MODE:    prdata = APB_DATA_W'(r_cfg.anim_mode);
            REG_FRAME_RATE:   prdata = APB_DATA_W'(r_cfg.frame_rate);
            REG_SPEED_FACTOR: prdata = APB_DATA_W'(r_cfg.speed_factor);
            default:          prdata = '0;
        endcase
    end

    sfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    sfs_datapath #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SPRITE_BITS (SPRITE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (w_cmd),
        .i_elapsed       (i_in.elapsed),
        .i_entry_slot    (i_in.entry_slot),
        .i_entry_sprite  (i_in.entry_sprite),
        .i_start_frame   (i_in.start_frame),
        .o_sts           (w_sts),
        .o_sprite_id     (o_out.sprite_id),
        .o_frame_pos     (o_out.frame_pos),
        .o_still_playing (o_out.still_playing)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    `SFS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load,
        !o_out.valid || o_out.ready, "result overwritten before transfer")
    `SFS_ASSERT_NEXT(a_valid_from_load, i_clk, i_rst_n, !o_out.valid && !w_cmd.out_load,
        !o_out.valid, "result valid without a load")
    `SFS_ASSERT_SAME(a_pos_in_clip, i_clk, i_rst_n, o_out.valid,
        FC_W'(o_out.frame_pos) < r_cfg.frame_count, "result frame outside the clip")

endmodule

// ===== tb/sv/sprite_frame_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer unit testbench
// Fills the frame table, then drives directed and random tick, load and
// restart transfers through a series of clip settings. A scoreboard keeps
// its own copy of the playback state, predicts each frame result, and
// checks every result transfer in order. Both sides may idle at random.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit_tb;
    import sfs_pkg::*;

    localparam int unsigned             WATCHDOG_LIMIT = 1000;
    localparam int unsigned             SETTLE_CYCLES  = 32;
    localparam logic [OP_W-1:0]         OP_UNUSED      = 2'd3;
    localparam logic [MODE_W-1:0]       MODE_UNUSED_5  = 3'd5;
    localparam logic [MODE_W-1:0]       MODE_UNUSED_7  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [ELAPSED_W-1:0] elapsed;
        logic [SLOT_W-1:0]    entry_slot;
        logic [SPRITE_W-1:0]  entry_sprite;
        logic [START_W-1:0]   start_frame;
    } frame_item_t;

    typedef struct packed {
        logic [SPRITE_W-1:0] sprite_id;
        logic [FPOS_W-1:0]   frame_pos;
        logic                still_playing;
    } frame_result_t;

    class sprite_playback_scoreboard;
        logic [SPRITE_W-1:0] frame_tbl [MAX_FRAMES_DEF];
        logic [FPOS_W-1:0]   cur_pos;
        logic [FRAC_W-1:0]   frac_phase;
        bit                  playing;
        bit                  reversing;
        logic [FC_W-1:0]     frame_count;
        logic [MODE_W-1:0]   anim_mode;
        logic [RATE_W-1:0]   frame_rate;
        logic [SPEED_W-1:0]  speed_factor;
        frame_result_t       expected_frames[$];
        int unsigned         mismatches;

        function new();
            foreach (frame_tbl[i]) frame_tbl[i] = '0;
            cur_pos      = '0;
            frac_phase   = '0;
            playing      = 1'b1;
            reversing    = 1'b0;
            frame_count  = '0;
            anim_mode    = MODE_LOOP;
            frame_rate   = '0;
            speed_factor = SPEED_RESET;
            mismatches   = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        function void set_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_FRAME_COUNT:  frame_count  = value[FC_W-1:0];
                REG_ANIM_MODE:    anim_mode    = value[MODE_W-1:0];
                REG_FRAME_RATE:   frame_rate   = value[RATE_W-1:0];
                REG_SPEED_FACTOR: speed_factor = value[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned advance_index(int unsigned p, int unsigned n,
                                            int unsigned adv);
            int unsigned k;
            int unsigned d;
            case (anim_mode)
                MODE_ONESHOT: begin
                    if (adv >= n - p) begin
                        p = n - 1;
                        playing = 1'b0;
                    end else begin
                        p = p + adv;
                    end
                end
                MODE_LOOP: p = (p + adv % n) % n;
                MODE_PINGPONG: begin
                    for (k = 0; k < adv; k++) begin
                        if (reversing) begin
                            if (p == 0) begin
                                p = (n > 1) ? 1 : 0;
                                reversing = 1'b0;
                            end else begin
                                p = p - 1;
                            end
                        end else if (p + 1 >= n) begin
                            p = (n >= 2) ? n - 2 : 0;
                            reversing = 1'b1;
                        end else begin
                            p = p + 1;
                        end
                    end
                end
                MODE_REV_ONESHOT: begin
                    if (adv > p) begin
                        p = 0;
                        playing = 1'b0;
                    end else begin
                        p = p - adv;
                    end
                end
                MODE_REV_LOOP: begin
                    d = adv % n;
                    p = (d > p) ? p + n - d : p - d;
                end
                default: ;
            endcase
            return p;
        endfunction

        function void note_input(frame_item_t it);
            logic [47:0]   prod;
            logic [28:0]   total;
            int unsigned   n;
            int unsigned   adv;
            int unsigned   p;
            frame_result_t r;
            case (it.opcode)
                OP_LOAD: frame_tbl[it.entry_slot] = it.entry_sprite;
                OP_RESTART: begin
                    cur_pos    = it.start_frame;
                    playing    = 1'b1;
                    frac_phase = '0;
                    reversing  = 1'b0;
                end
                OP_TICK: begin
                    n = (32'(frame_count) > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF
                                                            : 32'(frame_count);
                    if (playing && n != 0 && frame_rate != '0) begin
                        prod = 48'(it.elapsed) * 48'(speed_factor) * 48'(frame_rate);
                        total = 29'(frac_phase) + 29'(prod >> 20);
                        adv = 32'(total[28:16]);
                        frac_phase = total[15:0];
                        p = 32'(cur_pos);
                        if (p >= n) p = n - 1;
                        if (adv > 0) p = advance_index(p, n, adv);
                        cur_pos = FPOS_W'(p);
                        r.sprite_id     = frame_tbl[SLOT_W'(p)];
                        r.frame_pos     = FPOS_W'(p);
                        r.still_playing = playing;
                        expected_frames.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        task check_result(frame_result_t got);
            frame_result_t want;
            if (expected_frames.size() == 0) begin
                report($sformatf("unexpected result: sprite %h pos %0d playing %0b",
                                 got.sprite_id, got.frame_pos, got.still_playing));
                return;
            end
            want = expected_frames.pop_front();
            if (got.sprite_id !== want.sprite_id || got.frame_pos !== want.frame_pos ||
                got.still_playing !== want.still_playing) begin
                report($sformatf("sprite %h/%h pos %0d/%0d playing %0b/%0b (got/exp)",
                                 got.sprite_id, want.sprite_id, got.frame_pos,
                                 want.frame_pos, got.still_playing, want.still_playing));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    send_idle_en;
    bit                    recv_stall_en;
    int unsigned           quiet_cycles = 0;

    sprite_playback_scoreboard frames_sb = new();

    sfs_in_if  in_ch ();
    sfs_out_if out_ch ();

    sprite_frame_sequencer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin : result_monitor
        frame_result_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.sprite_id     = out_ch.sprite_id;
            got.frame_pos     = out_ch.frame_pos;
            got.still_playing = out_ch.still_playing;
            frames_sb.check_result(got);
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sprite_frame_sequencer_unit verification failed");
            $finish;
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        repeat (6) @(posedge clk);
        forever begin
            if (recv_stall_en && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    function automatic frame_item_t make_item(logic [OP_W-1:0] op,
                                              logic [ELAPSED_W-1:0] elapsed,
                                              logic [SLOT_W-1:0] slot,
                                              logic [SPRITE_W-1:0] sprite,
                                              logic [START_W-1:0] start);
        frame_item_t it;
        it.opcode       = op;
        it.elapsed      = elapsed;
        it.entry_slot   = slot;
        it.entry_sprite = sprite;
        it.start_frame  = start;
        return it;
    endfunction

    function automatic frame_item_t random_item();
        frame_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      it.opcode = OP_TICK;
        else if (pick < 72) it.opcode = OP_RESTART;
        else if (pick < 95) it.opcode = OP_LOAD;
        else                it.opcode = OP_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 4)       it.elapsed = ELAPSED_W'($urandom_range(0, 4095));
        else if (pick < 7)  it.elapsed = ELAPSED_W'($urandom_range(0, 65535));
        else if (pick == 7) it.elapsed = '0;
        else if (pick == 8) it.elapsed = '1;
        else                it.elapsed = ELAPSED_W'($urandom_range(4096, 16383));
        it.entry_slot   = SLOT_W'($urandom_range(0, 15));
        it.entry_sprite = SPRITE_W'($urandom);
        it.start_frame  = START_W'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic send_item(frame_item_t it);
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= it.opcode;
        in_ch.elapsed      <= it.elapsed;
        in_ch.entry_slot   <= it.entry_slot;
        in_ch.entry_sprite <= it.entry_sprite;
        in_ch.start_frame  <= it.start_frame;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        frames_sb.note_input(it);
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (frames_sb.expected_frames.size() != 0);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        frames_sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic run_setting(logic [FC_W-1:0] fc, logic [MODE_W-1:0] mode,
                               logic [RATE_W-1:0] rate, logic [SPEED_W-1:0] speed,
                               int unsigned count, bit idle_en, bit hold_mid);
        frame_item_t it;
        int unsigned sent;
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_FRAME_COUNT, APB_DATA_W'(fc));
        write_reg(REG_ANIM_MODE, APB_DATA_W'(mode));
        write_reg(REG_FRAME_RATE, APB_DATA_W'(rate));
        write_reg(REG_SPEED_FACTOR, APB_DATA_W'(speed));
        send_idle_en  = idle_en;
        recv_stall_en = idle_en;
        sent = 0;
        while (sent < count) begin
            it = random_item();
            send_item(it);
            if (it.opcode != OP_UNUSED) sent++;
            // hold the sender until the block has drained
            if (hold_mid && sent == count / 2) wait_results_done();
        end
    endtask

    initial begin
        int unsigned k;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= '0;
        in_ch.elapsed      <= '0;
        in_ch.entry_slot   <= '0;
        in_ch.entry_sprite <= '0;
        in_ch.start_frame  <= '0;
        send_idle_en        = 1'b1;
        recv_stall_en       = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_FRAME_COUNT, APB_DATA_W'(4));
        write_reg(REG_ANIM_MODE, APB_DATA_W'(MODE_LOOP));
        write_reg(REG_FRAME_RATE, APB_DATA_W'(7680));
        write_reg(REG_SPEED_FACTOR, APB_DATA_W'(4096));

        // fill every slot so no tick reads an unset entry
        for (k = 0; k < MAX_FRAMES_DEF; k++) begin
            send_item(make_item(OP_LOAD, '0, SLOT_W'(k), SPRITE_W'(16'h1111 * k), '0));
        end
        send_item(make_item(OP_TICK, 16'h0000, '0, '0, '0));
        send_item(make_item(OP_TICK, 16'hFFFF, '0, '0, '0));
        send_item(make_item(OP_RESTART, '0, '0, '0, 4'd15));
        send_item(make_item(OP_TICK, 16'h0001, '0, '0, '0));
        send_item(make_item(OP_UNUSED, '1, '1, '1, '1));
        send_item(make_item(OP_RESTART, '1, '1, '1, 4'd0));
        send_item(make_item(OP_TICK, 16'd2185, '0, '0, '0));
        send_item(make_item(OP_TICK, 16'd2185, '1, '1, '1));

        run_setting(5'd8,  MODE_ONESHOT,     16'd3072,  16'd4096,  110, 1'b1, 1'b0);
        run_setting(5'd16, MODE_PINGPONG,    16'd3072,  16'd8192,  110, 1'b0, 1'b0);
        run_setting(5'd1,  MODE_PINGPONG,    16'hFFFF,  16'hFFFF,  100, 1'b1, 1'b0);
        run_setting(5'd31, MODE_REV_ONESHOT, 16'd5000,  16'd4096,  110, 1'b1, 1'b0);
        run_setting(5'd5,  MODE_REV_LOOP,    16'hFFFF,  16'hFFFF,  110, 1'b1, 1'b1);
        run_setting(5'd0,  MODE_LOOP,        16'd7680,  16'd4096,   60, 1'b1, 1'b0);
        run_setting(5'd6,  MODE_LOOP,        16'd0,     16'd4096,   60, 1'b1, 1'b0);
        run_setting(5'd7,  MODE_UNUSED_5,    16'd2560,  16'd4096,   80, 1'b1, 1'b0);
        run_setting(5'd3,  MODE_ONESHOT,     16'd7680,  16'd0,      60, 1'b1, 1'b0);
        run_setting(5'd2,  MODE_UNUSED_7,    16'hFFFF,  16'd2048,   60, 1'b1, 1'b0);
        run_setting(5'd1,  MODE_ONESHOT,     16'd7680,  16'd4096,   60, 1'b1, 1'b0);
        for (k = 0; k < 3; k++) begin
            run_setting(FC_W'($urandom_range(1, 16)), MODE_W'($urandom_range(0, 4)),
                        RATE_W'($urandom_range(1, 65535)), SPEED_W'($urandom),
                        110, 1'b1, 1'b0);
        end
        run_setting(5'd12, MODE_PINGPONG,    16'd6000,  16'd4096,  160, 1'b0, 1'b0);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (frames_sb.mismatches == 0) begin
            $display("sprite_frame_sequencer_unit verification clean");
        end else begin
            $display("sprite_frame_sequencer_unit verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/sfs_pkg.sv
design/sfs_stream_if.sv
design/sfs_ram.sv
design/sfs_ctrl.sv
design/sfs_datapath.sv
design/sprite_frame_sequencer_unit.sv
tb/sv/sprite_frame_sequencer_unit_tb.sv
